FILE: src/btvrg_pkg.sv
// ----------------------------------------------------------------------------
// btvrg_pkg: shared types and constants for the BTV gradient block
// Geometry limits, register indexes, window and weight types.
// ----------------------------------------------------------------------------
package btvrg_pkg;

   localparam int MAX_HALF   = 3;
   localparam int MAX_WIDTH  = 2048;
   localparam int NL         = 2 * MAX_HALF + 1;
   localparam int NW         = 2 * MAX_HALF + 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 12;
   localparam int BANK_W     = $clog2(NL);
   localparam int IDX_W      = $clog2(NW);
   localparam int HALF_W     = 2;
   localparam int CH_W       = 8;
   localparam int PIX_W      = 3 * CH_W;
   localparam int WGT_W      = 17;
   localparam int GRAD_W     = 23;
   localparam int FW_W       = 12;
   localparam int FH_W       = 13;
   localparam int MAX_HEIGHT = 4096;
   localparam int ONE_Q16    = 65536;
   localparam int HALF_Q16   = 32768;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_WIDTH   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_HEIGHT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY        = 3'd4;

   typedef logic [PIX_W-1:0]                      pix_type;
   typedef logic [NL-1:0][PIX_W-1:0]              bank_data_type;
   typedef logic [NW-1:0][NW-1:0][PIX_W-1:0]      pix_win_type;
   typedef logic [NW-1:0][NW-1:0][CH_W-1:0]       chan_win_type;
   typedef logic [NW-1:0][WGT_W-1:0]              weight_set_type;

   typedef struct packed {
      logic [HALF_W-1:0] kh;
      logic [HALF_W-1:0] kw;
      logic [HALF_W-1:0] reach;
   } geom_type;

   typedef struct packed {
      logic             valid;
      logic             emit;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } meta_type;

   typedef enum logic [1:0] {
      WGT_IDLE  = 2'b01,
      WGT_BUILD = 2'b10
   } wgt_state_type;

endpackage

FILE: src/btvrg_linebuf.sv
// ----------------------------------------------------------------------------
// btvrg_linebuf: line storage
// One bank per line; writes one bank, reads the same column of every bank.
// ----------------------------------------------------------------------------
module btvrg_linebuf (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic                              rd_en,
   input  logic [btvrg_pkg::BANK_W-1:0]      bank,
   input  logic [btvrg_pkg::COL_W-1:0]       addr,
   input  btvrg_pkg::pix_type                wdata,
   output btvrg_pkg::bank_data_type          rdata
);

   btvrg_pkg::bank_data_type rd_ff;

   for (genvar b = 0; b < btvrg_pkg::NL; b++) begin : g_bank
      logic [btvrg_pkg::PIX_W-1:0] mem [btvrg_pkg::MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (wr_en && bank == btvrg_pkg::BANK_W'(b)) begin
            mem[addr] <= wdata;
         end
         if (rd_en) begin
            rd_ff[b] <= mem[addr];
         end
      end
   end

   assign rdata = rd_ff;

endmodule

FILE: src/btvrg_weights.sv
// ----------------------------------------------------------------------------
// btvrg_weights: decay power table
// Rebuild w(k) = (w(k-1)*decay + 0.5) >> 16, one entry per cycle.
// ----------------------------------------------------------------------------
module btvrg_weights (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [btvrg_pkg::WGT_W-1:0]        decay,
   output btvrg_pkg::weight_set_type          weights,
   output logic                               busy
);

   btvrg_pkg::wgt_state_type          state_ff, state_in;
   logic [btvrg_pkg::IDX_W-1:0]       idx_ff, idx_in;
   btvrg_pkg::weight_set_type         w_ff;
   logic [btvrg_pkg::WGT_W-1:0]       alpha;
   logic [2*btvrg_pkg::WGT_W-1:0]     prod;

   // saturate alpha at one
   assign alpha = (decay > btvrg_pkg::WGT_W'(btvrg_pkg::ONE_Q16))
                  ? btvrg_pkg::WGT_W'(btvrg_pkg::ONE_Q16) : decay;
   assign prod  = (2*btvrg_pkg::WGT_W)'(w_ff[idx_ff - 1'b1]) * (2*btvrg_pkg::WGT_W)'(alpha)
                  + (2*btvrg_pkg::WGT_W)'(btvrg_pkg::HALF_Q16);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         btvrg_pkg::WGT_IDLE: begin
            state_in = btvrg_pkg::WGT_IDLE;
         end
         btvrg_pkg::WGT_BUILD: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == btvrg_pkg::IDX_W'(btvrg_pkg::NW - 1)) begin
               state_in = btvrg_pkg::WGT_IDLE;
            end
         end
         default: begin
            state_in = btvrg_pkg::WGT_IDLE;
         end
      endcase
      if (start) begin
         state_in = btvrg_pkg::WGT_BUILD;
         idx_in   = btvrg_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btvrg_pkg::WGT_BUILD;
         idx_ff   <= btvrg_pkg::IDX_W'(1);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff[0] <= btvrg_pkg::WGT_W'(btvrg_pkg::ONE_Q16);
      if (state_ff == btvrg_pkg::WGT_BUILD) begin
         w_ff[idx_ff] <= prod[btvrg_pkg::WGT_W+15:16];
      end
   end

   assign weights = w_ff;
   assign busy    = (state_ff == btvrg_pkg::WGT_BUILD);

endmodule

FILE: src/btvrg_lane.sv
// ----------------------------------------------------------------------------
// btvrg_lane: gradient for one color channel
// Sign terms, per-row weighted partial sums, final sum: three stages.
// ----------------------------------------------------------------------------
module btvrg_lane (
   input  logic                                   clock,
   input  logic                                   adv,
   input  btvrg_pkg::geom_type                    geom,
   input  btvrg_pkg::weight_set_type              weights,
   input  btvrg_pkg::chan_win_type                win,
   output logic signed [btvrg_pkg::GRAD_W-1:0]    grad
);

   localparam int MH = btvrg_pkg::MAX_HALF;
   localparam int NL = btvrg_pkg::NL;
   localparam int GW = btvrg_pkg::GRAD_W;

   logic signed [2:0]    d_ff   [MH+1][NL];
   logic signed [2:0]    d_in   [MH+1][NL];
   logic signed [GW-1:0] psum_ff [MH+1];
   logic signed [GW-1:0] psum_in [MH+1];
   logic signed [GW-1:0] grad_ff, grad_in;

   // sign differences for every enabled (m, l)
   always_comb begin
      int                  l;
      logic [2:0]          j1, k1, j2, k2;
      logic [7:0]          c, p1, p2;
      logic signed [2:0]   s1, s2;
      j1 = '0;
      k1 = '0;
      j2 = '0;
      k2 = '0;
      p1 = '0;
      p2 = '0;
      s1 = '0;
      s2 = '0;
      c = win[{1'b0, geom.reach}][{1'b0, geom.kh}];
      for (int m = 0; m <= MH; m++) begin
         for (int li = 0; li < NL; li++) begin
            l = li - MH;
            d_in[m][li] = '0;
            if (l >= -m && m <= int'(geom.kh) && l <= int'(geom.kw)) begin
               j1 = 3'(int'(geom.kh) - m);
               k1 = 3'(int'(geom.reach) - l);
               j2 = 3'(int'(geom.kh) + m);
               k2 = 3'(int'(geom.reach) + l);
               p1 = win[k1][j1];
               p2 = win[k2][j2];
               s1 = (c > p1) ? 3'sd1 : ((c < p1) ? -3'sd1 : 3'sd0);
               s2 = (p2 > c) ? 3'sd1 : ((p2 < c) ? -3'sd1 : 3'sd0);
               d_in[m][li] = s1 - s2;
            end
         end
      end
   end

   // weighted sum along each row offset
   always_comb begin
      logic signed [GW-1:0] wv;
      for (int m = 0; m <= MH; m++) begin
         psum_in[m] = '0;
         for (int li = 0; li < NL; li++) begin
            wv = GW'(weights[m + ((li < MH) ? (MH - li) : (li - MH))]);
            if (d_ff[m][li] == 3'sd1) begin
               psum_in[m] = psum_in[m] + wv;
            end else if (d_ff[m][li] == -3'sd1) begin
               psum_in[m] = psum_in[m] - wv;
            end else if (d_ff[m][li] == 3'sd2) begin
               psum_in[m] = psum_in[m] + (wv <<< 1);
            end else if (d_ff[m][li] == -3'sd2) begin
               psum_in[m] = psum_in[m] - (wv <<< 1);
            end
         end
      end
   end

   always_comb begin
      grad_in = '0;
      for (int m = 0; m <= MH; m++) begin
         grad_in = grad_in + psum_ff[m];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff    <= d_in;
         psum_ff <= psum_in;
         grad_ff <= grad_in;
      end
   end

   assign grad = grad_ff;

endmodule

FILE: src/btv_regularization_gradient.sv
// ----------------------------------------------------------------------------
// btv_regularization_gradient: bilateral TV regularization gradient
// Raster RGB pixels in, per-channel Q.16 gradients with centre coordinates out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns at most one result per pixel, at a
// sustained rate of one item per cycle. A result is offered once the pixel
// completing its window has passed the line-store read at its accepting edge,
// the window shift, three lane stages and the output register. Pixels that
// only fill the window, and border centres, give no result. The input stalls
// only while rsp_tready holds the output register full, and after reset and
// after every write of decay while the weight table is rebuilt one power per
// cycle through a single 17x17 multiplier. Line storage is seven banks of
// 2048 pixels that are not cleared; write geometry only while no item is in
// flight.
// ----------------------------------------------------------------------------
module btv_regularization_gradient (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic [btvrg_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [btvrg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // pixel input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // red, green, blue
   input  logic                                req_tuser,  // frame_start
   // gradient output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [95:0]                         rsp_tdata,  // out_row, out_col,
                                                           // grad_red, grad_green,
                                                           // grad_blue, zero pad
   output logic                                rsp_tlast   // frame_last
);

   localparam int NL   = btvrg_pkg::NL;
   localparam int NW   = btvrg_pkg::NW;
   localparam int CW   = btvrg_pkg::COL_W;
   localparam int RW   = btvrg_pkg::ROW_W;
   localparam int BW   = btvrg_pkg::BANK_W;
   localparam int GW   = btvrg_pkg::GRAD_W;
   localparam int FWW  = btvrg_pkg::FW_W;
   localparam int FHW  = btvrg_pkg::FH_W;
   localparam int NSTG = 5;

   // configuration registers
   logic [FWW-1:0]                  fw_ff;
   logic [FHW-1:0]                  fh_ff;
   logic [btvrg_pkg::HALF_W-1:0]    hw_ff, hh_ff;
   logic [btvrg_pkg::WGT_W-1:0]     decay_ff;
   logic                            decay_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= FWW'(640);
         fh_ff    <= FHW'(480);
         hw_ff    <= 2'd3;
         hh_ff    <= 2'd3;
         decay_ff <= 17'd45875;
      end else if (csr_we) begin
         case (csr_addr)
            btvrg_pkg::CSR_FRAME_WIDTH:  fw_ff    <= csr_wdata[FWW-1:0];
            btvrg_pkg::CSR_FRAME_HEIGHT: fh_ff    <= csr_wdata[FHW-1:0];
            btvrg_pkg::CSR_HALF_WIDTH:   hw_ff    <= csr_wdata[1:0];
            btvrg_pkg::CSR_HALF_HEIGHT:  hh_ff    <= csr_wdata[1:0];
            btvrg_pkg::CSR_DECAY:        decay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign decay_wr = csr_we && (csr_addr == btvrg_pkg::CSR_DECAY);

   // effective geometry
   btvrg_pkg::geom_type geom;
   logic [FWW-1:0]      wid;
   logic [FHW-1:0]      hei;

   always_comb begin
      geom.kh    = hh_ff;
      geom.kw    = hw_ff;
      geom.reach = (hw_ff > hh_ff) ? hw_ff : hh_ff;
      if (fw_ff == '0) begin
         wid = FWW'(1);
      end else if (fw_ff > FWW'(btvrg_pkg::MAX_WIDTH)) begin
         wid = FWW'(btvrg_pkg::MAX_WIDTH);
      end else begin
         wid = fw_ff;
      end
      if (fh_ff == '0) begin
         hei = FHW'(1);
      end else if (fh_ff > FHW'(btvrg_pkg::MAX_HEIGHT)) begin
         hei = FHW'(btvrg_pkg::MAX_HEIGHT);
      end else begin
         hei = fh_ff;
      end
   end

   // weight table
   btvrg_pkg::weight_set_type weights;
   logic                      wgt_busy;

   btvrg_weights u_weights (
      .clock   (clock),
      .reset   (reset),
      .start   (decay_wr),
      .decay   (decay_ff),
      .weights (weights),
      .busy    (wgt_busy)
   );

   // handshake: the whole pipeline advances while the output slot is free
   logic rsp_valid_ff;
   logic adv, accept;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv && !wgt_busy;
   assign accept     = req_tvalid && req_tready;

   // position of the incoming pixel; bank tracks row mod NL
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [BW-1:0] bank_ff, bank_in;
   logic [RW-1:0] ir;
   logic [CW-1:0] ic;
   logic [BW-1:0] ib;
   btvrg_pkg::meta_type meta0;

   always_comb begin
      logic [RW:0]   r;
      logic [CW:0]   c;
      logic [BW-1:0] b;
      logic [RW:0]   rn;
      logic [CW:0]   cn;
      logic [BW-1:0] bn;
      r = req_tuser ? '0 : {1'b0, row_ff};
      c = req_tuser ? '0 : {1'b0, col_ff};
      b = req_tuser ? '0 : bank_ff;
      // wrap a position left beyond a shrunk geometry
      if (c >= wid) begin
         c = '0;
         r = r + 1'b1;
         b = (b == BW'(NL - 1)) ? '0 : b + 1'b1;
      end
      if (r >= hei) begin
         r = '0;
         b = '0;
      end
      ir = r[RW-1:0];
      ic = c[CW-1:0];
      ib = b;

      meta0.valid = 1'b1;
      meta0.emit  = (ir >= RW'({geom.kh, 1'b0})) && (ic >= CW'({geom.reach, 1'b0}));
      meta0.last  = (r == hei - 1'b1) && (c == wid - 1'b1);
      meta0.row   = ir - RW'(geom.kh);
      meta0.col   = ic - CW'(geom.reach);

      // advance to the next position
      cn = c + 1'b1;
      rn = r;
      bn = b;
      if (cn >= wid) begin
         cn = '0;
         rn = r + 1'b1;
         bn = (b == BW'(NL - 1)) ? '0 : b + 1'b1;
         if (rn >= hei) begin
            rn = '0;
            bn = '0;
         end
      end
      row_in  = rn[RW-1:0];
      col_in  = cn[CW-1:0];
      bank_in = bn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         bank_ff <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         bank_ff <= bank_in;
      end
   end

   // line storage: write this pixel, read the same column of all lines
   btvrg_pkg::bank_data_type rd_data;

   btvrg_linebuf u_linebuf (
      .clock (clock),
      .wr_en (accept),
      .rd_en (accept),
      .bank  (ib),
      .addr  (ic),
      .wdata (req_tdata),
      .rdata (rd_data)
   );

   // stage metadata and stage-1 payload
   btvrg_pkg::meta_type meta_ff [1:NSTG];
   btvrg_pkg::pix_type  pix_s1_ff;
   logic [BW-1:0]       bank_s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= NSTG; s++) begin
            meta_ff[s].valid <= 1'b0;
         end
      end else if (adv) begin
         meta_ff[1].valid <= accept;
         for (int s = 2; s <= NSTG; s++) begin
            meta_ff[s].valid <= meta_ff[s-1].valid;
         end
      end
      if (accept) begin
         pix_s1_ff                             <= req_tdata;
         bank_s1_ff                            <= ib;
         {meta_ff[1].emit, meta_ff[1].last,
          meta_ff[1].row, meta_ff[1].col}      <= {meta0.emit, meta0.last,
                                                   meta0.row, meta0.col};
      end
      if (adv) begin
         for (int s = 2; s <= NSTG; s++) begin
            {meta_ff[s].emit, meta_ff[s].last, meta_ff[s].row, meta_ff[s].col} <=
               {meta_ff[s-1].emit, meta_ff[s-1].last, meta_ff[s-1].row,
                meta_ff[s-1].col};
         end
      end
   end

   // assemble the new column: row offset 0 is the live pixel
   btvrg_pkg::pix_type column [NW];

   always_comb begin
      int idx;
      column[0] = pix_s1_ff;
      for (int j = 1; j < NW; j++) begin
         idx = int'(bank_s1_ff) + NL - j;
         if (idx >= NL) begin
            idx = idx - NL;
         end
         column[j] = rd_data[BW'(idx)];
      end
   end

   // window: column offset 0 is the newest column
   btvrg_pkg::pix_win_type win_ff;

   always_ff @(posedge clock) begin
      if (adv && meta_ff[1].valid) begin
         for (int j = 0; j < NW; j++) begin
            win_ff[0][j] <= column[j];
         end
         for (int k = 1; k < NW; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   // one lane per color channel
   logic signed [GW-1:0] grad [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      btvrg_pkg::chan_win_type cwin;

      always_comb begin
         for (int k = 0; k < NW; k++) begin
            for (int j = 0; j < NW; j++) begin
               cwin[k][j] = win_ff[k][j][ch*btvrg_pkg::CH_W +: btvrg_pkg::CH_W];
            end
         end
      end

      btvrg_lane u_lane (
         .clock   (clock),
         .adv     (adv),
         .geom    (geom),
         .weights (weights),
         .win     (cwin),
         .grad    (grad[ch])
      );
   end

   // merge the lanes into the output item
   logic [91:0] rsp_data_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= meta_ff[NSTG].valid && meta_ff[NSTG].emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {grad[2], grad[1], grad[0], meta_ff[NSTG].col, meta_ff[NSTG].row};
         rsp_last_ff <= meta_ff[NSTG].last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: src/btvrg_checker.sv
// ----------------------------------------------------------------------------
// btvrg_checker: port-level checks for the BTV gradient block
// Output hold under stall, input gating by output and weight rebuild.
// ----------------------------------------------------------------------------
module btvrg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_we,
   input logic [btvrg_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input logic [btvrg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [23:0]                         req_tdata,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [95:0]                         rsp_tdata,
   input logic                                rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // input taken only when the output slot can move
   a_ready_gate: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("input ready while output blocked");

   // weight rebuild after reset blocks input
   a_reset_build: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("input ready during weight rebuild after reset");

   // weight rebuild after a decay write blocks input
   a_decay_build: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_addr == btvrg_pkg::CSR_DECAY |=> !req_tready)
      else $error("input ready during weight rebuild");

endmodule

bind btv_regularization_gradient btvrg_checker u_btvrg_checker (.*);
